// ===== design/wsds_pkg.sv =====
// Shared types, constants and helpers of the work-stealing deque scheduler.
`timescale 1ns / 1ps
`default_nettype none
package wsds_pkg;

   localparam int MAX_WORKERS_DEFAULT  = 8;
   localparam int DEQUE_DEPTH_DEFAULT  = 256;
   localparam int HANDLE_WIDTH_DEFAULT = 16;

   localparam int JOB_W    = 16;
   localparam int WORKER_W = 3;
   localparam int COUNT_W  = 4;

   localparam logic [COUNT_W-1:0] WORKER_COUNT_RESET = 4'd8;
   localparam logic [31:0] SEED_GOLDEN = 32'h9E37_79B9;
   localparam logic [31:0] SEED_MAIN   = 32'hA341_316C;

   // Kind of result the datapath registers for the result port.
   typedef enum logic [1:0] {
      RSP_PUSH_OK   = 2'd0,
      RSP_PUSH_FULL = 2'd1,
      RSP_NONE      = 2'd2,
      RSP_JOB       = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         push;
      logic         pop;
      logic         rand_step;
      logic         div_step;
      logic         scan_next;
      logic         steal;
      logic         use_victim;
      logic         respond;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic op_get;
      logic sel_empty;
      logic sel_full;
      logic multi;
      logic div_last;
      logic victim_ok;
      logic scan_last;
   } dp_status_type;

   // Generator seed of one worker after reset.
   function automatic logic [31:0] seed_of(input int idx);
      logic [31:0] prod;
      prod = SEED_GOLDEN * 32'(idx + 1);
      return (idx == 0) ? SEED_MAIN : (SEED_GOLDEN ^ prod);
   endfunction

endpackage
`default_nettype wire

// ===== design/wsds_ctrl.sv =====
// Controller state machine of the work-stealing deque scheduler.
`timescale 1ns / 1ps
`default_nettype none
module wsds_ctrl
   import wsds_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status_in,
   output dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status_in.op_get) begin
               cmd.respond = 1'b1;
               if (status_in.sel_full) begin
                  cmd.rsp_kind = RSP_PUSH_FULL;
               end else begin
                  cmd.push     = 1'b1;
                  cmd.rsp_kind = RSP_PUSH_OK;
               end
               state_in = ST_IDLE;
            end else if (!status_in.sel_empty) begin
               cmd.pop  = 1'b1;
               state_in = ST_READ;
            end else if (status_in.multi) begin
               cmd.rand_step = 1'b1;
               state_in      = ST_MOD;
            end else begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_NONE;
               state_in     = ST_IDLE;
            end
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            if (status_in.div_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.use_victim = 1'b1;
            if (status_in.victim_ok) begin
               cmd.steal = 1'b1;
               state_in  = ST_READ;
            end else if (status_in.scan_last) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_NONE;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_READ: begin
            cmd.respond  = 1'b1;
            cmd.rsp_kind = RSP_JOB;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/wsds_datapath.sv =====
// Datapath of the work-stealing deque scheduler: deques, indices, generators, divider.
`timescale 1ns / 1ps
`default_nettype none
module wsds_datapath
   import wsds_pkg::*;
#(
   parameter int MAX_WORKERS  = MAX_WORKERS_DEFAULT,
   parameter int DEQUE_DEPTH  = DEQUE_DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [COUNT_W-1:0]  csr_data,
   input  wire logic                req_op,
   input  wire logic [WORKER_W-1:0] req_worker,
   input  wire logic [JOB_W-1:0]    req_job_in,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status_out,
   output logic                     rsp_valid,
   output logic [JOB_W-1:0]         rsp_job_out,
   output logic                     rsp_found,
   output logic                     rsp_stolen,
   output logic [WORKER_W-1:0]      rsp_source_worker,
   output logic                     rsp_status
);

   localparam int WW     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int SLOT_W = $clog2(DEQUE_DEPTH);
   localparam int IDX_W  = $clog2(2 * DEQUE_DEPTH);
   localparam int ADDR_W = WW + SLOT_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam logic [IDX_W:0]   IDX_MOD_V = (IDX_W + 1)'(2 * DEQUE_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_V   = (IDX_W + 1)'(DEQUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(2 * DEQUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] N_CAP =
      (MAX_WORKERS >= 15) ? 4'd15 : COUNT_W'(MAX_WORKERS);

   // Configuration and captured transaction.
   logic [COUNT_W-1:0]      worker_count_ff;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic                    op_ff;
   logic [WW-1:0]           w_ff, w_in;
   logic [HANDLE_WIDTH-1:0] job_ff;

   // Per-worker state.
   logic [IDX_W-1:0] top_ff [MAX_WORKERS];
   logic [IDX_W-1:0] bot_ff [MAX_WORKERS];
   logic [31:0]      rand_ff [MAX_WORKERS];

   // Divider and scan.
   logic [31:0]        div_ff;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [2:0]         div_cnt_ff;
   logic [WW-1:0]      v_ff;
   logic [2:0]         scan_cnt_ff;
   logic               stolen_ff;
   logic [WW-1:0]      src_ff;

   // Deque storage.
   logic [HANDLE_WIDTH-1:0] mem [MEM_DEPTH];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;

   // Result registers.
   logic                    rsp_valid_ff;
   logic [JOB_W-1:0]        rsp_job_ff;
   logic                    rsp_found_ff;
   logic                    rsp_stolen_ff;
   logic [WORKER_W-1:0]     rsp_src_ff;
   logic                    rsp_status_ff;

   // Combinational helpers.
   logic [WW-1:0]    sel;
   logic [IDX_W-1:0] sel_top, sel_bot, bot_dec, top_inc, bot_inc;
   logic [IDX_W:0]   occ;
   logic [31:0]      rnd_next;
   logic [WW-1:0]    v_last;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      r = (idx >= IDX_W'(DEQUE_DEPTH)) ? (idx - IDX_W'(DEQUE_DEPTH)) : idx;
      return r[SLOT_W-1:0];
   endfunction

   // Reduce the incoming worker number into range and clamp the worker count.
   always_comb begin
      logic [WORKER_W-1:0] r;
      r = req_worker;
      if (MAX_WORKERS < 8) begin
         for (int k = 0; k < 8; k++) begin
            if ({1'b0, r} >= COUNT_W'(MAX_WORKERS)) begin
               r = r - WORKER_W'(MAX_WORKERS);
            end
         end
      end
      w_in = WW'(r);
      if (worker_count_ff == '0) begin
         n_in = COUNT_W'(1);
      end else if (worker_count_ff > N_CAP) begin
         n_in = N_CAP;
      end else begin
         n_in = worker_count_ff;
      end
   end

   assign sel     = cmd.use_victim ? v_ff : w_ff;
   assign sel_top = top_ff[sel];
   assign sel_bot = bot_ff[sel];
   assign occ = (sel_bot >= sel_top) ? ({1'b0, sel_bot} - {1'b0, sel_top})
                                     : ({1'b0, sel_bot} + IDX_MOD_V - {1'b0, sel_top});
   assign bot_dec = (sel_bot == '0) ? IDX_LAST : (sel_bot - IDX_W'(1));
   assign bot_inc = (sel_bot == IDX_LAST) ? '0 : (sel_bot + IDX_W'(1));
   assign top_inc = (sel_top == IDX_LAST) ? '0 : (sel_top + IDX_W'(1));
   assign wr_addr = {sel, slot_of(sel_bot)};
   assign rd_addr = {sel, slot_of(cmd.pop ? bot_dec : sel_top)};
   assign v_last  = WW'(n_ff - COUNT_W'(1));

   always_comb begin
      logic [31:0] x;
      x = rand_ff[w_ff];
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rnd_next = x;
   end

   // Four remainder steps per cycle; the remainder stays below the count.
   always_comb begin
      logic [COUNT_W:0] t;
      rem_in = rem_ff;
      for (int k = 0; k < 4; k++) begin
         t = {rem_in, div_ff[31-k]};
         if (t >= {1'b0, n_ff}) begin
            t = t - {1'b0, n_ff};
         end
         rem_in = t[COUNT_W-1:0];
      end
   end

   always_comb begin
      status_out.op_get    = op_ff;
      status_out.sel_empty = (sel_top == sel_bot);
      status_out.sel_full  = (occ >= DEPTH_V);
      status_out.multi     = (n_ff > COUNT_W'(1));
      status_out.div_last  = (div_cnt_ff == 3'd7);
      status_out.victim_ok = (v_ff != w_ff) && (sel_top != sel_bot);
      status_out.scan_last = ({1'b0, scan_cnt_ff} == (n_ff - COUNT_W'(1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WORKER_COUNT_RESET;
      end else if (csr_valid) begin
         worker_count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WORKERS; i++) begin
            top_ff[i]  <= '0;
            bot_ff[i]  <= '0;
            rand_ff[i] <= seed_of(i);
         end
      end else begin
         if (cmd.push) begin
            bot_ff[sel] <= bot_inc;
         end
         if (cmd.pop) begin
            bot_ff[sel] <= bot_dec;
         end
         if (cmd.steal) begin
            top_ff[sel] <= top_inc;
         end
         if (cmd.rand_step) begin
            rand_ff[w_ff] <= rnd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         w_ff   <= w_in;
         n_ff   <= n_in;
         job_ff <= HANDLE_WIDTH'(req_job_in);
      end
      if (cmd.rand_step) begin
         div_ff     <= rnd_next;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         div_ff      <= div_ff << 4;
         rem_ff      <= rem_in;
         div_cnt_ff  <= div_cnt_ff + 3'd1;
         v_ff        <= WW'(rem_in);
         scan_cnt_ff <= '0;
      end
      if (cmd.scan_next) begin
         v_ff        <= (v_ff == v_last) ? '0 : (v_ff + WW'(1));
         scan_cnt_ff <= scan_cnt_ff + 3'd1;
      end
      if (cmd.pop || cmd.steal) begin
         stolen_ff <= cmd.steal;
         src_ff    <= sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= job_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop || cmd.steal) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         case (cmd.rsp_kind)
            RSP_PUSH_FULL: begin
               rsp_job_ff    <= '0;
               rsp_found_ff  <= 1'b0;
               rsp_stolen_ff <= 1'b0;
               rsp_src_ff    <= '0;
               rsp_status_ff <= 1'b1;
            end
            RSP_JOB: begin
               rsp_job_ff    <= JOB_W'(rd_data_ff);
               rsp_found_ff  <= 1'b1;
               rsp_stolen_ff <= stolen_ff;
               rsp_src_ff    <= WORKER_W'(src_ff);
               rsp_status_ff <= 1'b0;
            end
            default: begin
               rsp_job_ff    <= '0;
               rsp_found_ff  <= 1'b0;
               rsp_stolen_ff <= 1'b0;
               rsp_src_ff    <= '0;
               rsp_status_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_job_out       = rsp_job_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_stolen        = rsp_stolen_ff;
   assign rsp_source_worker = rsp_src_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
`default_nettype wire

// ===== design/work_stealing_deque_scheduler_unit.sv =====
// Top level of the work-stealing deque scheduler.
`timescale 1ns / 1ps
`default_nettype none
// The scheduler keeps one bounded ring deque of job handles per worker. A push
// transaction places a handle at the worker's bottom, or reports status 1 when
// that deque is full. A get transaction pops the worker's own newest entry;
// when its deque is empty and more than one worker is enabled, the worker's
// xorshift32 generator picks a start modulo the worker count, and the other
// enabled deques are scanned in turn, the oldest entry of the first non-empty
// one being stolen. Transactions are taken when start is high and busy is low,
// one at a time. Each transaction produces exactly one result, shown on the
// rsp_ ports for a single cycle with rsp_valid high; the receiver cannot stall
// it, so it must capture the result in that cycle. From the accepting edge, a
// push passes the check state and the result register, and a local pop the
// check state, the registered deque read and the result register. A steal
// passes the check state, which tests the requester's deque and advances its
// generator, then the remainder unit (four bits of the 32-bit draw per cycle),
// then a scan of k victims, one per cycle (k up to the worker count), the
// registered deque read and the result register. A get that finds nothing
// responds after the full scan, or from the check state with a single worker.
// busy stays high until the result is registered. The worker count register
// is written through csr_valid at any idle moment; csr_ready is always high.
module work_stealing_deque_scheduler_unit
   import wsds_pkg::*;
#(
   parameter int MAX_WORKERS  = MAX_WORKERS_DEFAULT,
   parameter int DEQUE_DEPTH  = DEQUE_DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_op,
   input  wire logic [WORKER_W-1:0] req_worker,
   input  wire logic [JOB_W-1:0]    req_job_in,
   output logic                     rsp_valid,
   output logic [JOB_W-1:0]         rsp_job_out,
   output logic                     rsp_found,
   output logic                     rsp_stolen,
   output logic [WORKER_W-1:0]      rsp_source_worker,
   output logic                     rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COUNT_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   // The register write is always accepted.
   assign csr_ready = 1'b1;

   // The controller sequences each transaction; it sees the datapath only
   // through the command and status structures.
   wsds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status_in (dp_status),
      .cmd       (cmd)
   );

   // The datapath holds the deques, their indices, the generators, the
   // remainder unit and the result registers.
   wsds_datapath #(
      .MAX_WORKERS  (MAX_WORKERS),
      .DEQUE_DEPTH  (DEQUE_DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .req_op            (req_op),
      .req_worker        (req_worker),
      .req_job_in        (req_job_in),
      .cmd               (cmd),
      .status_out        (dp_status),
      .rsp_valid         (rsp_valid),
      .rsp_job_out       (rsp_job_out),
      .rsp_found         (rsp_found),
      .rsp_stolen        (rsp_stolen),
      .rsp_source_worker (rsp_source_worker),
      .rsp_status        (rsp_status)
   );

endmodule
`default_nettype wire
